@@ hw/rtl/pci_pkg.sv @@
// ----------------------------------------------------------------------------
// pci_pkg
// Shared types, constants and helpers of the PID controller with integral clamp.
// ----------------------------------------------------------------------------
package pci_pkg;

    localparam int PCI_FRAC_BITS = 16;

    // serial multiplier: A operand width, B operand width, product width
    localparam int MUL_A_W  = 64;
    localparam int MUL_B_W  = 33;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DIVSR_W  = 32;

    localparam logic [DIVSR_W-1:0] MS_PER_S = 32'd1000;

    typedef enum logic [1:0] {
        CFG_GAIN_P  = 2'd0,
        CFG_GAIN_I  = 2'd1,
        CFG_GAIN_D  = 2'd2,
        CFG_I_CAP   = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL,
        S_IMUL1,
        S_IMUL2,
        S_IDIV,
        S_DMUL1,
        S_DMUL2,
        S_DDIV,
        S_FINISH
    } pci_state_t;

    // saturate a sign/magnitude value to 32-bit signed
    function automatic logic signed [31:0] sm_sat(input logic neg, input logic [PROD_W-1:0] mag);
        logic big;
        big = |mag[PROD_W-1:31];
        if (neg)
            sm_sat = big ? 32'sh8000_0000 : $signed(-mag[31:0]);
        else
            sm_sat = big ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
            sat34 = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            sat34 = 32'sh8000_0000;
        else
            sat34 = v[31:0];
    endfunction

endpackage

@@ hw/rtl/pci_mul.sv @@
// ----------------------------------------------------------------------------
// pci_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pci_mul
    import pci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_A_W-1:0]   a,
    input  logic [MUL_B_W-1:0]   b,
    output logic                 done,
    output logic [PROD_W-1:0]    prod
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_A_W-1:0] hi_reg, hi_next;
    logic [MUL_B_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_A_W:0]   sum;

    always_comb
    begin
        sum = lo_reg[0] ? ({1'b0, hi_reg} + {1'b0, a_reg}) : {1'b0, hi_reg};
        hi_next = sum[MUL_A_W:1];
        lo_next = {sum[0], lo_reg[MUL_B_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

@@ hw/rtl/pci_div.sv @@
// ----------------------------------------------------------------------------
// pci_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pci_div
    import pci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PROD_W-1:0]    dividend,
    input  logic [DIVSR_W-1:0]   divisor,
    output logic                 done,
    output logic [PROD_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic [DIVSR_W-1:0] dvs_reg;
    logic [DIVSR_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0]  q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIVSR_W:0]   trial;
    logic               qbit;

    always_comb
    begin
        trial = {rem_reg, q_reg[PROD_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        rem_next = qbit ? DIVSR_W'(trial - {1'b0, dvs_reg}) : trial[DIVSR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[PROD_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hw/rtl/pid_controller_integral_clamp.sv @@
// One item at a time. Each item takes five bit-serial multiplies and two
// bit-serial divides, run in turn on shared units.
// A new item is taken while the previous result waits in the output register.
// Reset: asynchronous, clears gains, cap, integral, last error and last time.
// ----------------------------------------------------------------------------
// pid_controller_integral_clamp
// PID controller in signed fixed point with a clamped integral term.
// ----------------------------------------------------------------------------
module pid_controller_integral_clamp
    import pci_pkg::*;
#(
    parameter int FRAC_BITS = PCI_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured,
    input  logic signed [31:0] target,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] drive,
    output logic signed [31:0] error_out,
    output logic signed [31:0] integral_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    pci_state_t state_reg, state_next;
    logic go_reg;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0]        cap_reg;
    logic signed [31:0] acc_reg, last_err_reg;
    logic [31:0]        last_time_reg;

    logic signed [31:0] err_reg;
    logic [MUL_B_W-1:0] diff_mag_reg;
    logic               diff_neg_reg;
    logic [31:0]        dt_reg, now_reg;
    logic signed [31:0] p_reg, inc_reg, d_reg;
    logic [MUL_A_W-1:0] x_mag_reg;
    logic               x_neg_reg;

    logic               out_valid_reg;
    logic signed [31:0] drive_reg, err_out_reg, integ_out_reg;

    logic               mul_start, mul_done, div_start, div_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod, div_quo;
    logic [PROD_W-1:0]  prod_scaled;
    logic [DIVSR_W-1:0] div_dvs;

    logic               accept, finish_fire;
    logic signed [32:0] err_wide, diff_wide;
    logic signed [31:0] err_sat;
    logic [31:0]        dt_raw;
    logic signed [31:0] acc_new;
    logic signed [32:0] cap_s;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign finish_fire = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    // ---- input stage ----
    always_comb
    begin
        err_wide = {target[31], target} - {measured[31], measured};
        if (err_wide > 33'sh0_7FFF_FFFF)
            err_sat = 32'sh7FFF_FFFF;
        else if (err_wide < -33'sh0_8000_0000)
            err_sat = 32'sh8000_0000;
        else
            err_sat = err_wide[31:0];
        diff_wide = {last_err_reg[31], last_err_reg} - {err_sat[31], err_sat};
        dt_raw = now_ms - last_time_reg;
    end

    // ---- state machine ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_PMUL;
            S_PMUL:   if (mul_done) state_next = S_IMUL1;
            S_IMUL1:  if (mul_done) state_next = S_IMUL2;
            S_IMUL2:  if (mul_done) state_next = S_IDIV;
            S_IDIV:   if (div_done) state_next = S_DMUL1;
            S_DMUL1:  if (mul_done) state_next = S_DMUL2;
            S_DMUL2:  if (mul_done) state_next = S_DDIV;
            S_DDIV:   if (div_done) state_next = S_FINISH;
            S_FINISH: if (finish_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        mul_start = go_reg && (state_reg == S_PMUL || state_reg == S_IMUL1 ||
                    state_reg == S_IMUL2 || state_reg == S_DMUL1 || state_reg == S_DMUL2);
        div_start = go_reg && (state_reg == S_IDIV || state_reg == S_DDIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next != state_reg);
        end
    end

    // ---- operand selection ----
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PMUL:
            begin
                mul_a = MUL_A_W'(abs32(gain_p_reg));
                mul_b = MUL_B_W'(abs32(err_reg));
            end
            S_IMUL1:
            begin
                mul_a = MUL_A_W'(abs32(gain_i_reg));
                mul_b = MUL_B_W'(abs32(err_reg));
            end
            S_IMUL2:
            begin
                mul_a = x_mag_reg;
                mul_b = MUL_B_W'(dt_reg);
            end
            S_DMUL1:
            begin
                mul_a = MUL_A_W'(abs32(gain_d_reg));
                mul_b = diff_mag_reg;
            end
            S_DMUL2:
            begin
                mul_a = x_mag_reg;
                mul_b = MUL_B_W'(MS_PER_S);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        div_dvs = (state_reg == S_DDIV) ? dt_reg : MS_PER_S;
        prod_scaled = mul_prod >> FRAC_BITS;
    end

    pci_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---- final combine ----
    always_comb
    begin
        cap_s   = $signed({2'b00, cap_reg});
        acc_new = sat34({{2{acc_reg[31]}}, acc_reg} + {{2{inc_reg[31]}}, inc_reg});
        if (gain_i_reg == 32'sd0)
            acc_new = 32'sd0;
        if ($signed({acc_new[31], acc_new}) > cap_s)
            acc_new = $signed({1'b0, cap_reg});
        else if ($signed({acc_new[31], acc_new}) < -cap_s)
            acc_new = 32'(-cap_s);
    end

    // ---- datapath registers ----
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg      <= err_sat;
            diff_neg_reg <= diff_wide[32];
            diff_mag_reg <= diff_wide[32] ? MUL_B_W'(-diff_wide) : MUL_B_W'(diff_wide);
            dt_reg       <= (dt_raw == 32'd0) ? 32'd1 : dt_raw;
            now_reg      <= now_ms;
        end
        if (mul_done)
        begin
            case (state_reg)
                S_PMUL:  p_reg <= sm_sat(gain_p_reg[31] ^ err_reg[31], prod_scaled);
                S_IMUL1:
                begin
                    x_mag_reg <= prod_scaled[MUL_A_W-1:0];
                    x_neg_reg <= gain_i_reg[31] ^ err_reg[31];
                end
                S_DMUL1:
                begin
                    x_mag_reg <= prod_scaled[MUL_A_W-1:0];
                    x_neg_reg <= gain_d_reg[31] ^ diff_neg_reg;
                end
                default: ;
            endcase
        end
        if (div_done)
        begin
            if (state_reg == S_IDIV)
                inc_reg <= sm_sat(x_neg_reg, div_quo);
            else
                d_reg <= sm_sat(x_neg_reg, div_quo);
        end
        if (finish_fire)
        begin
            drive_reg     <= sat34({{2{p_reg[31]}}, p_reg} + {{2{acc_new[31]}}, acc_new}
                                   + {{2{d_reg[31]}}, d_reg});
            err_out_reg   <= err_reg;
            integ_out_reg <= acc_new;
        end
    end

    // ---- control state, configuration and output handshake ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            cap_reg       <= '0;
            acc_reg       <= '0;
            last_err_reg  <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GAIN_P: gain_p_reg <= cfg_data;
                    CFG_GAIN_I: gain_i_reg <= cfg_data;
                    CFG_GAIN_D: gain_d_reg <= cfg_data;
                    CFG_I_CAP:  cap_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (finish_fire)
            begin
                acc_reg       <= acc_new;
                last_err_reg  <= err_reg;
                last_time_reg <= now_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive        = drive_reg;
    assign error_out    = err_out_reg;
    assign integral_out = integ_out_reg;

`ifndef NO_ASSERTIONS
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_start && div_start))
        else $error("multiplier and divider started together");

    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PMUL) && go_reg)
        else $error("accepted item did not launch the P multiply");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        finish_fire |=> ($signed({integral_out[31], integral_out})
                         <= $signed({2'b00, cap_reg}))
                     && ($signed({integral_out[31], integral_out})
                         >= -$signed({2'b00, cap_reg})))
        else $error("integral exceeds cap");
`endif

endmodule
